>>> hdl/frm_pkg.sv
// Package for the fraction reduce block: shared defaults and width helpers.
// No dependencies; imported by frm_core and fraction_reduce_mixed_top.
package frm_pkg;

    localparam int unsigned DATA_WIDTH_DEF = 32;

    function automatic int unsigned byte_pad(input int unsigned bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

>>> hdl/frm_sub.sv
// Shared subtract and compare unit of the fraction reduce block.
// No dependencies; instanced once inside frm_core.
module frm_sub #(
    parameter int unsigned WIDTH = 33
) (
    input  logic [WIDTH-1:0] i_x,
    input  logic [WIDTH-1:0] i_y,
    output logic [WIDTH-1:0] o_diff,
    output logic             o_borrow,
    output logic             o_zero
);

    assign {o_borrow, o_diff} = {1'b0, i_x} - {1'b0, i_y};
    assign o_zero = (o_diff == '0) && !o_borrow;

endmodule

>>> hdl/frm_core.sv
// Sequencer and working registers: magnitudes, binary gcd, restoring divides, signs.
// Depends on frm_pkg; the single frm_sub unit does every subtract, negate and compare.
module frm_core
    import frm_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_num,
    input  logic [DATA_WIDTH-1:0] i_den,
    output logic                  o_idle,
    output logic                  o_res_valid,
    input  logic                  i_res_take,
    output logic [DATA_WIDTH-1:0] o_reduced_num,
    output logic [DATA_WIDTH-1:0] o_reduced_den,
    output logic [DATA_WIDTH-1:0] o_whole_part,
    output logic [DATA_WIDTH-1:0] o_proper_num,
    output logic                  o_zero_den_error
);

    localparam int unsigned W     = DATA_WIDTH;
    localparam int unsigned UW    = DATA_WIDTH + 1;
    localparam int unsigned CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(DATA_WIDTH - 1);
    localparam logic [W-1:0]      SIGN_BIT = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_MAGN, S_MAGD, S_PRE, S_GCD, S_DIV,
        S_ENCN, S_ENCD, S_CMP, S_ENCW, S_ENCP, S_DONE
    } t_state;

    typedef enum logic [1:0] {DV_N, DV_D, DV_Q} t_dsel;

    t_state           r_state;
    t_dsel            r_dsel;
    logic             r_nneg, r_dneg, r_err;
    logic [W-1:0]     r_a, r_b, r_n2, r_d2, r_div, r_quo, r_rem;
    logic [W-1:0]     r_nred, r_dred, r_rn, r_rd, r_whole, r_proper;
    logic [CNT_W-1:0] r_cnt;

    logic [UW-1:0]    w_x, w_y, w_diff, w_shift;
    logic             w_borrow, w_zero;
    logic [W-1:0]     w_neg, w_bmag, w_quo_nxt, w_rem_nxt;

    frm_sub #(.WIDTH(UW)) u_sub (
        .i_x      (w_x),
        .i_y      (w_y),
        .o_diff   (w_diff),
        .o_borrow (w_borrow),
        .o_zero   (w_zero)
    );

    assign w_shift   = {r_rem, r_quo[W-1]};
    assign w_neg     = w_diff[W-1:0];
    assign w_bmag    = r_dneg ? w_neg : r_b;
    assign w_quo_nxt = {r_quo[W-2:0], !w_borrow};
    assign w_rem_nxt = w_borrow ? w_shift[W-1:0] : w_diff[W-1:0];

    always_comb begin
        w_x = '0;
        w_y = '0;
        unique case (r_state)
            S_MAGN: w_y = {1'b0, r_a};
            S_MAGD: w_y = {1'b0, r_b};
            S_GCD: begin
                w_x = {1'b0, r_a};
                w_y = {1'b0, r_b};
            end
            S_DIV: begin
                w_x = w_shift;
                w_y = {1'b0, r_div};
            end
            S_ENCN: w_y = {1'b0, r_nred};
            S_ENCD: w_y = {1'b0, r_dred};
            S_CMP: begin
                w_x = {1'b0, r_rn ^ SIGN_BIT};
                w_y = {1'b0, r_rd ^ SIGN_BIT};
            end
            S_ENCW: w_y = {1'b0, r_whole};
            S_ENCP: w_y = {1'b0, r_proper};
            default: begin
                w_x = '0;
                w_y = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_num;
                        r_b     <= i_den;
                        r_nneg  <= i_num[W-1];
                        r_dneg  <= i_den[W-1];
                        r_err   <= 1'b0;
                        r_state <= S_MAGN;
                    end
                end
                S_MAGN: begin
                    if (r_nneg) begin
                        r_a <= w_neg;
                    end
                    r_state <= S_MAGD;
                end
                S_MAGD: begin
                    if (r_b == '0) begin
                        r_err    <= 1'b1;
                        r_rn     <= '0;
                        r_rd     <= '0;
                        r_whole  <= '0;
                        r_proper <= '0;
                        r_state  <= S_DONE;
                    end else begin
                        r_b <= w_bmag;
                        if (r_a == '0) begin
                            r_n2    <= '0;
                            r_d2    <= w_bmag;
                            r_div   <= w_bmag;
                            r_quo   <= '0;
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_dsel  <= DV_N;
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_PRE;
                        end
                    end
                end
                S_PRE: begin
                    if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                    end else begin
                        r_n2    <= r_a;
                        r_d2    <= r_b;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    priority if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (w_zero) begin
                        r_div   <= r_a;
                        r_quo   <= r_n2;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_dsel  <= DV_N;
                        r_state <= S_DIV;
                    end else if (w_borrow) begin
                        r_a <= r_b;
                        r_b <= r_a;
                    end else begin
                        r_a <= w_diff[W:1];
                    end
                end
                S_DIV: begin
                    if (r_cnt == CNT_LAST) begin
                        r_cnt <= '0;
                        unique case (r_dsel)
                            DV_N: begin
                                r_nred <= w_quo_nxt;
                                r_quo  <= r_d2;
                                r_rem  <= '0;
                                r_dsel <= DV_D;
                            end
                            DV_D: begin
                                r_dred  <= w_quo_nxt;
                                r_state <= S_ENCN;
                            end
                            DV_Q: begin
                                r_whole  <= w_quo_nxt;
                                r_proper <= w_rem_nxt;
                                r_state  <= S_ENCW;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end else begin
                        r_quo <= w_quo_nxt;
                        r_rem <= w_rem_nxt;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ENCN: begin
                    r_rn    <= r_nneg ? w_neg : r_nred;
                    r_state <= S_ENCD;
                end
                S_ENCD: begin
                    r_rd    <= r_dneg ? w_neg : r_dred;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (!w_borrow && !w_zero) begin
                        r_quo   <= r_nred;
                        r_rem   <= '0;
                        r_div   <= r_dred;
                        r_cnt   <= '0;
                        r_dsel  <= DV_Q;
                        r_state <= S_DIV;
                    end else begin
                        r_whole  <= '0;
                        r_proper <= r_rn;
                        r_state  <= S_DONE;
                    end
                end
                S_ENCW: begin
                    r_whole <= (r_nneg ^ r_dneg) ? w_neg : r_whole;
                    r_state <= S_ENCP;
                end
                S_ENCP: begin
                    r_proper <= r_nneg ? w_neg : r_proper;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idle           = (r_state == S_IDLE);
    assign o_res_valid      = (r_state == S_DONE);
    assign o_reduced_num    = r_rn;
    assign o_reduced_den    = r_rd;
    assign o_whole_part     = r_whole;
    assign o_proper_num     = r_proper;
    assign o_zero_den_error = r_err;

endmodule

>>> hdl/fraction_reduce_mixed_top.sv
// Top level of the fraction reduce block: stream ports, output register, checks.
// Depends on frm_pkg and frm_core (which holds frm_sub).
//
// Usage: a beat on s_axis carries a signed numerator and denominator. The block
// takes the magnitudes, finds their gcd with a binary gcd, divides both by it,
// restores the signs and, when the reduced numerator exceeds the denominator,
// splits off the truncated whole part and the proper remainder numerator.
// One result beat on m_axis follows each input beat; tuser flags a zero
// denominator, in which case all tdata fields are zero.
// The time from the accepting edge to m_axis_tvalid grows with each common factor
// of two and each gcd shift, subtract or swap, and with the whole-part divide
// when it is taken. A zero numerator skips the gcd; a zero denominator goes
// straight from the magnitude step to the result.
// s_axis_tready is high only while the sequencer is idle; one item is in work,
// and the next beat is taken in the cycle after the result leaves the sequencer.
// The result moves into an output register, so a new item is taken while a
// finished beat waits on a stalled m_axis_tready; a second result then waits in
// the sequencer. Reset clears the sequencer and the output valid.
module fraction_reduce_mixed_top
    import frm_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // numerator, denominator
    input  logic [byte_pad(2*DATA_WIDTH)-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // reduced_num, reduced_den, whole_part, proper_num
    output logic [byte_pad(4*DATA_WIDTH)-1:0]     m_axis_tdata,
    // zero_den_error
    output logic                                  m_axis_tuser
);

    localparam int unsigned W      = DATA_WIDTH;
    localparam int unsigned OUT_W  = byte_pad(4*DATA_WIDTH);

    logic         w_idle, w_res_valid, w_take, w_err;
    logic [W-1:0] w_rn, w_rd, w_whole, w_proper;

    logic                 r_out_valid;
    logic [4*W-1:0]       r_out_data;
    logic                 r_out_user;

    frm_core #(.DATA_WIDTH(DATA_WIDTH)) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (s_axis_tvalid && w_idle),
        .i_num            (s_axis_tdata[W-1:0]),
        .i_den            (s_axis_tdata[2*W-1:W]),
        .o_idle           (w_idle),
        .o_res_valid      (w_res_valid),
        .i_res_take       (w_take),
        .o_reduced_num    (w_rn),
        .o_reduced_den    (w_rd),
        .o_whole_part     (w_whole),
        .o_proper_num     (w_proper),
        .o_zero_den_error (w_err)
    );

    assign w_take = w_res_valid && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {w_proper, w_whole, w_rd, w_rn};
                r_out_user  <= w_err;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign s_axis_tready = w_idle;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_data);
    assign m_axis_tuser  = r_out_user;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("block ready again right after taking a beat");

    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("zero denominator beat carries nonzero fields");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[2*W-1:W] != '0))
        else $error("reduced denominator is zero without error flag");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && !w_take) |=> (w_res_valid && $stable(w_rn) && $stable(w_proper)))
        else $error("finished result lost before handoff");
`endif

endmodule
